>>> src/tces_pkg.sv
// Package for the three-class event scheduler: field widths, request and
// result codes, and the packed structs shared by the scheduler modules.
// Depends on nothing.
`default_nettype none

package tces_pkg;

	// Fixed widths of the request and result fields.
	localparam int NUM_CLASSES = 3;
	localparam int CLS_W       = 2;
	localparam int ID_W        = 8;
	localparam int TICK_W      = 64;
	localparam int DUE_W       = 63;
	localparam int DELAY_W     = 16;
	localparam int TPC_W       = 20;
	localparam int PROD_W      = DELAY_W + TPC_W;

	// An advance fires at most this many events before it reports done.
	localparam int MAX_FIRES  = 48;
	localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

	localparam logic [TPC_W-1:0] TPC_RESET = 20'd1000;

	// Request types.
	localparam logic [1:0] REQ_TICKS    = 2'd0;
	localparam logic [1:0] REQ_CYCLES   = 2'd1;
	localparam logic [1:0] REQ_PERIODIC = 2'd2;
	localparam logic [1:0] REQ_ADVANCE  = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_DROPPED  = 2'd1;
	localparam logic [1:0] KIND_FIRED    = 2'd2;
	localparam logic [1:0] KIND_DONE     = 2'd3;

	// Timing classes.
	localparam logic [CLS_W-1:0] CLS_PRE  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_AT   = 2'd1;
	localparam logic [CLS_W-1:0] CLS_POST = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [ID_W-1:0]    event_id;
		logic [CLS_W-1:0]   timing_class;
		logic [DELAY_W-1:0] delay;
	} req_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ID_W-1:0]  fired_id;
		logic [CLS_W-1:0] fired_class;
		logic [DUE_W-1:0] due_tick;
		logic             last;
	} res_t;

	// One queued event.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] tick;
		logic              periodic;
	} entry_t;

	// Commands from the sequencer to the queue store.
	typedef struct packed {
		logic             push;
		logic [CLS_W-1:0] push_cls;
		entry_t           push_entry;
		logic             pop;
		logic [CLS_W-1:0] pop_cls;
	} q_cmd_t;

	// Status from the queue store.
	typedef struct packed {
		logic [NUM_CLASSES-1:0] full;
		logic                   refill;
	} q_stat_t;

	// The nearest front entry over the three queues.
	typedef struct packed {
		logic             found;
		logic             due;
		logic [CLS_W-1:0] cls;
		entry_t           entry;
	} pick_t;

endpackage

`default_nettype wire

>>> src/three_class_event_scheduler.sv
// Three-class event scheduler. A request is taken when start is high and
// busy is low. A schedule request gives one result: the delay product is
// registered when the request is taken, then the schedule state adds it to
// the current tick, writes the queue RAM and registers the result. An
// advance request steps the tick when it is taken, then fires due events in
// turn, pausing after a fire from a queue that still holds entries behind
// its front (the RAM read that reloads that queue's front register), and
// ends with the done result; at most 48 events fire per advance. Results
// appear for exactly one cycle with result_valid high and cannot be held off,
// so the receiver must take every one. No clearing pass runs after reset.
// Depends on tces_pkg and tces_queues.
`default_nettype none

module three_class_event_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire tces_pkg::req_t              request,
	output logic                             busy,
	output logic                             result_valid,
	output tces_pkg::res_t                   result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [tces_pkg::TPC_W-1:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCHED = 2'd1;
	localparam logic [1:0] ST_FIRE  = 2'd2;

	logic [1:0]                        state_q;
	logic [1:0]                        state_d;
	logic [tces_pkg::TICK_W-1:0]       now_q;
	logic [tces_pkg::TPC_W-1:0]        tpc_q;
	logic [tces_pkg::FIRE_CNT_W-1:0]   fire_cnt_q;
	tces_pkg::req_t                    req_s1;
	logic [tces_pkg::PROD_W-1:0]       addend_s1;
	logic [tces_pkg::PROD_W-1:0]       addend_d;
	logic                              result_valid_q;
	tces_pkg::res_t                    result_q;
	logic                              res_fire;
	tces_pkg::res_t                    res_d;
	logic [tces_pkg::TICK_W-1:0]       sched_due;
	logic                              sched_ok;
	logic                              fire_go;
	tces_pkg::q_cmd_t                  cmd;
	tces_pkg::q_stat_t                 stat;
	tces_pkg::pick_t                   pick;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// Offset to the due tick, one multiply at most.
	always_comb begin
		case (request.req_type)
			tces_pkg::REQ_TICKS:  addend_d = tces_pkg::PROD_W'(request.delay);
			tces_pkg::REQ_CYCLES: addend_d = tces_pkg::PROD_W'(request.delay) *
				tces_pkg::PROD_W'(tpc_q);
			default:              addend_d = tces_pkg::PROD_W'(tpc_q);
		endcase
	end

	// Schedule acceptance against the queue state.
	assign sched_due = now_q + tces_pkg::TICK_W'(addend_s1);
	assign sched_ok  = (req_s1.timing_class == tces_pkg::CLS_PRE && !stat.full[0]) ||
		(req_s1.timing_class == tces_pkg::CLS_AT && !stat.full[1]) ||
		(req_s1.timing_class == tces_pkg::CLS_POST && !stat.full[2]);

	assign fire_go = pick.found && pick.due &&
		(fire_cnt_q != tces_pkg::FIRE_CNT_W'(tces_pkg::MAX_FIRES));

	// Sequencer: queue commands, next result and next state.
	always_comb begin
		state_d                 = state_q;
		res_fire                = 1'b0;
		res_d                   = '0;
		cmd                     = '0;
		cmd.push_entry.id       = pick.entry.id;
		cmd.push_entry.tick     = pick.entry.tick + tces_pkg::TICK_W'(tpc_q);
		cmd.push_entry.periodic = 1'b1;
		cmd.push_cls            = pick.cls;
		cmd.pop_cls             = pick.cls;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (request.req_type == tces_pkg::REQ_ADVANCE) ? ST_FIRE : ST_SCHED;
				end
			end
			ST_SCHED: begin
				cmd.push                = sched_ok;
				cmd.push_cls            = req_s1.timing_class;
				cmd.push_entry.id       = req_s1.event_id;
				cmd.push_entry.tick     = sched_due;
				cmd.push_entry.periodic = (req_s1.req_type == tces_pkg::REQ_PERIODIC);
				res_fire                = 1'b1;
				res_d.kind        = sched_ok ? tces_pkg::KIND_ACCEPTED : tces_pkg::KIND_DROPPED;
				res_d.fired_id    = req_s1.event_id;
				res_d.fired_class = req_s1.timing_class;
				res_d.due_tick    = sched_due[tces_pkg::DUE_W-1:0];
				res_d.last        = 1'b1;
				state_d           = ST_IDLE;
			end
			ST_FIRE: begin
				if (!stat.refill) begin
					res_fire = 1'b1;
					if (fire_go) begin
						cmd.pop           = 1'b1;
						cmd.push          = pick.entry.periodic;
						res_d.kind        = tces_pkg::KIND_FIRED;
						res_d.fired_id    = pick.entry.id;
						res_d.fired_class = pick.cls;
						res_d.due_tick    = pick.entry.tick[tces_pkg::DUE_W-1:0];
						res_d.last        = 1'b0;
					end else begin
						res_d.kind     = tces_pkg::KIND_DONE;
						res_d.due_tick = now_q[tces_pkg::DUE_W-1:0];
						res_d.last     = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			now_q          <= '0;
			tpc_q          <= tces_pkg::TPC_RESET;
			fire_cnt_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= res_fire;
			if (cfg_valid && cfg_ready) begin
				tpc_q <= cfg_data;
			end
			if (state_q == ST_IDLE && start) begin
				fire_cnt_q <= '0;
				if (request.req_type == tces_pkg::REQ_ADVANCE) begin
					now_q <= now_q + tces_pkg::TICK_W'(tpc_q);
				end
			end else if (cmd.pop) begin
				fire_cnt_q <= fire_cnt_q + tces_pkg::FIRE_CNT_W'(1);
			end
		end
	end

	// Request stage and result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_s1    <= request;
			addend_s1 <= addend_d;
		end
		if (res_fire) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	tces_queues #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queues (
		.clk    (clk),
		.arst_n (arst_n),
		.now    (now_q),
		.cmd    (cmd),
		.stat   (stat),
		.pick   (pick)
	);

	// The block goes idle only together with the final result of a request.
	a_idle_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && result.last))
		else $error("block went idle without a final result");

	// A fired event is never the last result, so the block is still busy.
	a_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == tces_pkg::KIND_FIRED) |-> (busy && !result.last))
		else $error("fired result outside an advance");

	// A schedule request answers with its final result once the schedule state has registered it.
	a_sched_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.req_type != tces_pkg::REQ_ADVANCE) |=>
			##1 (result_valid && result.last))
		else $error("schedule result missing");

endmodule

`default_nettype wire

>>> src/tces_entry_ram.sv
// Entry store for the event queues: one write port and one read port with
// registered read data. Depends on tces_pkg for the entry type.
`default_nettype none

module tces_entry_ram #(
	parameter int DEPTH = 48,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire tces_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output tces_pkg::entry_t     rdata
);

	tces_pkg::entry_t mem [DEPTH];
	tces_pkg::entry_t rdata_q;

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/tces_queues.sv
// Three FIFO event queues: head and count registers, a cached front entry
// per queue, the shared entry RAM and the nearest-front selection.
// Depends on tces_pkg and tces_entry_ram.
`default_nettype none

module tces_queues #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [tces_pkg::TICK_W-1:0]   now,
	input  wire tces_pkg::q_cmd_t              cmd,
	output tces_pkg::q_stat_t                  stat,
	output tces_pkg::pick_t                    pick
);

	localparam int NC        = tces_pkg::NUM_CLASSES;
	localparam int PW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int SW        = CW + 1;
	localparam int RAM_DEPTH = NC * QUEUE_DEPTH;
	localparam int AW        = $clog2(RAM_DEPTH);

	logic [PW-1:0]    head_q     [NC];
	logic [CW-1:0]    count_q    [NC];
	tces_pkg::entry_t front_q    [NC];
	logic             refill_q;
	logic [tces_pkg::CLS_W-1:0] refill_cls_q;

	logic [NC-1:0]    pop_v;
	logic [NC-1:0]    push_v;
	logic [NC-1:0]    nonempty_v;
	logic [NC-1:0]    full_v;
	logic [NC-1:0]    le_v;
	logic [PW-1:0]    next_head [NC];
	logic [AW-1:0]    waddr_c   [NC];
	logic [AW-1:0]    raddr_c   [NC];
	logic [SW-1:0]    tail_sum  [NC];

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	tces_pkg::entry_t ram_rdata;

	logic             g01;
	logic             g02;
	logic             g12;
	logic             a_is1;
	logic             pick2;

	// Per-queue decode: which queue is pushed or popped, where its tail lies
	// and where the entry behind its front sits in the RAM.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		for (int c = 0; c < NC; c++) begin
			pop_v[c]      = cmd.pop && (cmd.pop_cls == tces_pkg::CLS_W'(c));
			push_v[c]     = cmd.push && (cmd.push_cls == tces_pkg::CLS_W'(c));
			nonempty_v[c] = (count_q[c] != '0);
			full_v[c]     = (count_q[c] == CW'(QUEUE_DEPTH));
			le_v[c]       = (front_q[c].tick <= now);
			next_head[c]  = (head_q[c] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q[c] + PW'(1);
			tail_sum[c]   = SW'(head_q[c]) + SW'(count_q[c]);
			if (tail_sum[c] >= SW'(QUEUE_DEPTH)) begin
				tail_sum[c] = tail_sum[c] - SW'(QUEUE_DEPTH);
			end
			waddr_c[c] = AW'(c * QUEUE_DEPTH) + AW'(tail_sum[c][PW-1:0]);
			raddr_c[c] = AW'(c * QUEUE_DEPTH) + AW'(next_head[c]);
			if (push_v[c]) begin
				ram_we    = 1'b1;
				ram_waddr = waddr_c[c];
			end
			if (pop_v[c] && (count_q[c] > CW'(1))) begin
				ram_re    = 1'b1;
				ram_raddr = raddr_c[c];
			end
		end
	end

	// Head and count registers, and the pending front refill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NC; c++) begin
				head_q[c]  <= '0;
				count_q[c] <= '0;
			end
			refill_q     <= 1'b0;
			refill_cls_q <= '0;
		end else begin
			for (int c = 0; c < NC; c++) begin
				count_q[c] <= count_q[c] - CW'(pop_v[c]) + CW'(push_v[c]);
				if (pop_v[c]) begin
					head_q[c] <= next_head[c];
				end
			end
			refill_q     <= ram_re;
			refill_cls_q <= cmd.pop_cls;
		end
	end

	// Front cache: loaded from the RAM read that a pop starts, or directly
	// when a push lands in a queue that is or becomes empty.
	always_ff @(posedge clk) begin
		for (int c = 0; c < NC; c++) begin
			if (refill_q && (refill_cls_q == tces_pkg::CLS_W'(c))) begin
				front_q[c] <= ram_rdata;
			end else if (push_v[c] && ((count_q[c] == '0) ||
					(pop_v[c] && (count_q[c] == CW'(1))))) begin
				front_q[c] <= cmd.push_entry;
			end
		end
	end

	tces_entry_ram #(
		.DEPTH (RAM_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.push_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Nearest front: on equal ticks pre beats at and at beats post.
	always_comb begin
		g01   = front_q[0].tick > front_q[1].tick;
		g02   = front_q[0].tick > front_q[2].tick;
		g12   = front_q[1].tick > front_q[2].tick;
		a_is1 = !nonempty_v[0] || (nonempty_v[1] && g01);
		pick2 = !(nonempty_v[0] || nonempty_v[1]) ||
			(nonempty_v[2] && (a_is1 ? g12 : g02));
		pick.found = |nonempty_v;
		if (pick2) begin
			pick.cls   = tces_pkg::CLS_POST;
			pick.entry = front_q[2];
			pick.due   = le_v[2];
		end else if (a_is1) begin
			pick.cls   = tces_pkg::CLS_AT;
			pick.entry = front_q[1];
			pick.due   = le_v[1];
		end else begin
			pick.cls   = tces_pkg::CLS_PRE;
			pick.entry = front_q[0];
			pick.due   = le_v[0];
		end
	end

	assign stat.full   = full_v;
	assign stat.refill = refill_q;

	// A pop always takes the selected, due front.
	a_pop_is_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (pick.found && pick.due && (cmd.pop_cls == pick.cls)))
		else $error("pop does not match the selected front");

	// No queue access while a front entry is being refilled.
	a_refill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		refill_q |-> (!cmd.pop && !cmd.push))
		else $error("queue access during front refill");

	// A push without a pop of the same queue never hits a full queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && !cmd.pop) |->
			!((cmd.push_cls == tces_pkg::CLS_PRE && full_v[0]) ||
			  (cmd.push_cls == tces_pkg::CLS_AT && full_v[1]) ||
			  (cmd.push_cls == tces_pkg::CLS_POST && full_v[2])))
		else $error("push into a full queue");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for three_class_event_scheduler: a queue-fed request driver,
// a result monitor that checks against a local copy of the three event queues.
// Depends on tces_pkg and the scheduler RTL.

module tb;

	localparam int QUEUE_DEPTH    = 16;
	localparam int WATCHDOG_LIMIT = 1000;
	// A timing class with no queue behind it.
	localparam logic [tces_pkg::CLS_W-1:0] CLS_NONE = 2'd3;

	typedef enum logic [1:0] {
		PEND_REQUEST,
		PEND_TPC_WRITE,
		PEND_DRAIN
	} pend_kind_t;

	typedef struct packed {
		pend_kind_t                  kind;
		tces_pkg::req_t              req;
		logic [tces_pkg::TPC_W-1:0]  tpc;
	} pending_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	tces_pkg::req_t              request = '0;
	logic                        busy;
	logic                        result_valid;
	tces_pkg::res_t              result;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [tces_pkg::TPC_W-1:0]  cfg_data = '0;

	// Handshake history from the last rising edge.
	logic              req_taken = 1'b0;
	logic              cfg_taken = 1'b0;
	logic              stimulus_drained = 1'b0;

	pending_t          pending_q[$];
	tces_pkg::res_t    outcome_q[$];
	int                sent_count = 0;
	int                quiet_cycles = 0;
	int                mismatch_count = 0;

	// Local copy of the scheduler state.
	logic [tces_pkg::TICK_W-1:0] now_tick;
	logic [tces_pkg::TPC_W-1:0]  tick_per_cycle;
	tces_pkg::entry_t            q_ring[tces_pkg::NUM_CLASSES][QUEUE_DEPTH];
	int                          q_head[tces_pkg::NUM_CLASSES];
	int                          q_fill[tces_pkg::NUM_CLASSES];

	three_class_event_scheduler #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0d ns: mismatch: %s", $time, msg);
	endtask

	// Appends an event to the tail of its class queue; false when the queue is full.
	function automatic bit file_event(input int cls, input logic [tces_pkg::ID_W-1:0] id,
			input logic [tces_pkg::TICK_W-1:0] due, input bit periodic);
		tces_pkg::entry_t slot;
		if (q_fill[cls] >= QUEUE_DEPTH) begin
			return 1'b0;
		end
		slot.id = id;
		slot.tick = due;
		slot.periodic = periodic;
		q_ring[cls][(q_head[cls] + q_fill[cls]) % QUEUE_DEPTH] = slot;
		q_fill[cls]++;
		return 1'b1;
	endfunction

	// Works out every result that one accepted request causes, in order.
	task automatic predict_outcomes(input tces_pkg::req_t rq);
		logic [tces_pkg::TICK_W-1:0] due;
		tces_pkg::res_t              r;
		tces_pkg::entry_t            e;
		int                          best;
		int                          fires;
		bit                          filed;
		if (rq.req_type != tces_pkg::REQ_ADVANCE) begin
			case (rq.req_type)
				tces_pkg::REQ_TICKS: due = now_tick + 64'(rq.delay);
				tces_pkg::REQ_CYCLES: due = now_tick + 64'(rq.delay) * 64'(tick_per_cycle);
				default: due = now_tick + 64'(tick_per_cycle);
			endcase
			filed = 1'b0;
			if (rq.timing_class != CLS_NONE) begin
				filed = file_event(int'(rq.timing_class), rq.event_id, due,
					rq.req_type == tces_pkg::REQ_PERIODIC);
			end
			r.kind = filed ? tces_pkg::KIND_ACCEPTED : tces_pkg::KIND_DROPPED;
			r.fired_id = rq.event_id;
			r.fired_class = rq.timing_class;
			r.due_tick = due[tces_pkg::DUE_W-1:0];
			r.last = 1'b1;
			outcome_q.insert(outcome_q.size(), r);
		end else begin
			now_tick = now_tick + 64'(tick_per_cycle);
			fires = 0;
			while (fires < tces_pkg::MAX_FIRES) begin
				// The nearest front wins; on a tie the lower class goes first.
				best = -1;
				for (int c = 0; c < tces_pkg::NUM_CLASSES; c++) begin
					if (q_fill[c] != 0) begin
						if (best < 0) begin
							best = c;
						end else if (q_ring[c][q_head[c]].tick <
								q_ring[best][q_head[best]].tick) begin
							best = c;
						end
					end
				end
				if (best < 0) begin
					break;
				end
				e = q_ring[best][q_head[best]];
				if (e.tick > now_tick) begin
					break;
				end
				q_head[best] = (q_head[best] + 1) % QUEUE_DEPTH;
				q_fill[best]--;
				r.kind = tces_pkg::KIND_FIRED;
				r.fired_id = e.id;
				r.fired_class = tces_pkg::CLS_W'(best);
				r.due_tick = e.tick[tces_pkg::DUE_W-1:0];
				r.last = 1'b0;
				outcome_q.insert(outcome_q.size(), r);
				fires++;
				if (e.periodic) begin
					void'(file_event(best, e.id, e.tick + 64'(tick_per_cycle), 1'b1));
				end
			end
			r.kind = tces_pkg::KIND_DONE;
			r.fired_id = '0;
			r.fired_class = tces_pkg::CLS_PRE;
			r.due_tick = now_tick[tces_pkg::DUE_W-1:0];
			r.last = 1'b1;
			outcome_q.insert(outcome_q.size(), r);
		end
	endtask

	task automatic queue_request(input logic [1:0] kind,
			input logic [tces_pkg::ID_W-1:0] id,
			input logic [tces_pkg::CLS_W-1:0] cls,
			input logic [tces_pkg::DELAY_W-1:0] dly);
		pending_t p;
		p.kind = PEND_REQUEST;
		p.req.req_type = kind;
		p.req.event_id = id;
		p.req.timing_class = cls;
		p.req.delay = dly;
		p.tpc = '0;
		pending_q.insert(pending_q.size(), p);
	endtask

	task automatic queue_tpc_write(input logic [tces_pkg::TPC_W-1:0] value);
		pending_t p;
		p = '0;
		p.kind = PEND_TPC_WRITE;
		p.tpc = value;
		pending_q.insert(pending_q.size(), p);
	endtask

	task automatic queue_drain();
		pending_t p;
		p = '0;
		p.kind = PEND_DRAIN;
		pending_q.insert(pending_q.size(), p);
	endtask

	// A handful of requests, mostly schedule requests scaled to the cycle length, then one to three advances.
	task automatic queue_random_burst(input int tpc, inout int budget);
		int n;
		int r;
		int adv;
		int lim;
		lim = (tpc * 3 > 65535) ? 65535 : tpc * 3;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 48) begin
				queue_request(tces_pkg::REQ_TICKS, tces_pkg::ID_W'($urandom_range(0, 255)),
					tces_pkg::CLS_W'($urandom_range(0, 2)),
					tces_pkg::DELAY_W'($urandom_range(0, lim)));
			end else if (r < 82) begin
				queue_request(tces_pkg::REQ_CYCLES, tces_pkg::ID_W'($urandom_range(0, 255)),
					tces_pkg::CLS_W'($urandom_range(0, 2)),
					tces_pkg::DELAY_W'($urandom_range(0, 3)));
			end else if (r < 86) begin
				queue_request(tces_pkg::REQ_PERIODIC, tces_pkg::ID_W'($urandom_range(0, 255)),
					tces_pkg::CLS_W'($urandom_range(0, 2)),
					tces_pkg::DELAY_W'($urandom_range(0, 65535)));
			end else if (r < 94) begin
				queue_request(2'($urandom_range(0, 1)), tces_pkg::ID_W'($urandom_range(0, 255)),
					tces_pkg::CLS_W'($urandom_range(0, 2)),
					tces_pkg::DELAY_W'($urandom_range(0, 65535)));
			end else begin
				queue_request(2'($urandom_range(0, 3)), tces_pkg::ID_W'($urandom_range(0, 255)),
					tces_pkg::CLS_W'($urandom_range(0, 3)),
					tces_pkg::DELAY_W'($urandom_range(0, 65535)));
			end
		end
		adv = $urandom_range(1, 3);
		for (int i = 0; i < adv; i++) begin
			queue_request(tces_pkg::REQ_ADVANCE, tces_pkg::ID_W'($urandom_range(0, 255)),
				tces_pkg::CLS_W'($urandom_range(0, 3)),
				tces_pkg::DELAY_W'($urandom_range(0, 65535)));
		end
		budget -= n + adv;
		if ($urandom_range(0, 99) < 5) begin
			queue_drain();
		end
	endtask

	// Stimulus, reset and the end of the run.
	initial begin : run_sequence
		int tpc;
		int budget;
		now_tick = '0;
		tick_per_cycle = tces_pkg::TPC_RESET;
		for (int c = 0; c < tces_pkg::NUM_CLASSES; c++) begin
			q_head[c] = 0;
			q_fill[c] = 0;
		end

		// Field extremes, every request type, the missing class and a held-back periodic.
		queue_request(tces_pkg::REQ_TICKS, 8'h00, tces_pkg::CLS_PRE, 16'h0000);
		queue_request(tces_pkg::REQ_TICKS, 8'hFF, tces_pkg::CLS_POST, 16'hFFFF);
		queue_request(tces_pkg::REQ_CYCLES, 8'hA5, tces_pkg::CLS_AT, 16'hFFFF);
		queue_request(tces_pkg::REQ_PERIODIC, 8'h5A, tces_pkg::CLS_AT, 16'h1234);
		queue_request(tces_pkg::REQ_TICKS, 8'hC3, CLS_NONE, 16'h0042);
		queue_request(tces_pkg::REQ_ADVANCE, 8'h77, tces_pkg::CLS_POST, 16'hFFFF);
		// Fill the pre-tick queue past its depth, then fire the lot.
		for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
			queue_request(tces_pkg::REQ_TICKS, tces_pkg::ID_W'(16 + i), tces_pkg::CLS_PRE,
				16'h0000);
		end
		queue_request(tces_pkg::REQ_ADVANCE, 8'h00, tces_pkg::CLS_PRE, 16'h0000);
		// A zero cycle length keeps a periodic event due, so the fire limit ends the walk.
		queue_tpc_write('0);
		queue_request(tces_pkg::REQ_PERIODIC, 8'h01, tces_pkg::CLS_PRE, 16'h0000);
		queue_request(tces_pkg::REQ_ADVANCE, 8'hFF, tces_pkg::CLS_AT, 16'h0000);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: tpc = 20'hFFFFF;
				1: tpc = 1;
				2: tpc = $urandom_range(2, 1000000);
				3: tpc = 1000;
				default: tpc = 7;
			endcase
			queue_tpc_write(tces_pkg::TPC_W'(tpc));
			budget = 73;
			while (budget > 0) begin
				queue_random_burst(tpc, budget);
			end
		end

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (!stimulus_drained || outcome_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Request and register-write driver; an offer is held until its request is taken.
	always @(negedge clk) begin : drive_requests
		logic     nxt_start;
		logic     nxt_cfg;
		pending_t head;
		nxt_start = start && !req_taken;
		nxt_cfg = cfg_valid && !cfg_taken;
		if (arst_n && !nxt_start && !nxt_cfg) begin
			if (pending_q.size() == 0) begin
				stimulus_drained <= 1'b1;
			end else begin
				case (pending_q[0].kind)
					PEND_REQUEST: begin
						// Random gaps, except for one long stretch of back-to-back requests.
						if ((sent_count >= 120 && sent_count < 220) ||
								$urandom_range(0, 99) >= 27) begin
							head = pending_q[0];
							pending_q.delete(0);
							nxt_start = 1'b1;
							request <= head.req;
							sent_count++;
						end
					end
					PEND_TPC_WRITE: begin
						// The register is only written once the block has gone quiet.
						if (outcome_q.size() == 0 && !busy) begin
							head = pending_q[0];
							pending_q.delete(0);
							nxt_cfg = 1'b1;
							cfg_data <= head.tpc;
						end
					end
					default: begin
						if (outcome_q.size() == 0 && !busy) begin
							pending_q.delete(0);
						end
					end
				endcase
			end
		end
		start <= nxt_start;
		cfg_valid <= nxt_cfg;
	end

	// Result monitor: checks each strobe against the oldest outcome, then predicts new ones.
	always @(posedge clk or negedge arst_n) begin : watch_results
		tces_pkg::res_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			req_taken <= start && !busy;
			cfg_taken <= cfg_valid && cfg_ready;

			if (result_valid) begin
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result kind %0d id 0x%0h with nothing expected",
						result.kind, result.fired_id));
				end else begin
					want = outcome_q[0];
					outcome_q.delete(0);
					if (result.kind !== want.kind) begin
						report_mismatch($sformatf("kind %0d, expected %0d (id 0x%0h)",
							result.kind, want.kind, want.fired_id));
					end
					if (result.fired_id !== want.fired_id) begin
						report_mismatch($sformatf("fired_id 0x%0h, expected 0x%0h",
							result.fired_id, want.fired_id));
					end
					if (result.fired_class !== want.fired_class) begin
						report_mismatch($sformatf("fired_class %0d, expected %0d (id 0x%0h)",
							result.fired_class, want.fired_class, want.fired_id));
					end
					if (result.due_tick !== want.due_tick) begin
						report_mismatch($sformatf("due_tick %0d, expected %0d (id 0x%0h)",
							result.due_tick, want.due_tick, want.fired_id));
					end
					if (result.last !== want.last) begin
						report_mismatch($sformatf("last %0b, expected %0b (id 0x%0h)",
							result.last, want.last, want.fired_id));
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				tick_per_cycle = cfg_data;
			end
			if (start && !busy) begin
				predict_outcomes(request);
			end

			// Watchdog on cycles in which nothing at all is accepted.
			if (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request or result for %0d cycles", quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

endmodule
